### hdl/fdt_pkg.sv
// ----------------------------------------------------------------------------
// fdt_pkg: fan duty and timer controller shared definitions
// Event and result beat types, register map, codes and limits.
// ----------------------------------------------------------------------------
package fdt_pkg;

  localparam int DUTY_W      = 7;
  localparam int TEMP_W      = 8;
  localparam int TIME_W      = 8;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int TIMER_SLOTS = 4;

  // Number of timer modes in use (2 to 4); the top mode is TIMER_MODES - 1.
  localparam int TIMER_MODES = 4;

  localparam logic [DUTY_W-1:0] DUTY_MAX  = DUTY_W'(100);
  localparam logic [DUTY_W-1:0] DUTY_STEP = DUTY_W'(5);
  localparam int                AUTO_GAIN = 3;
  localparam int                AUTO_DIFF_MAX = 100 / AUTO_GAIN;
  localparam logic [MODE_W-1:0] MODE_TOP  = MODE_W'(TIMER_MODES - 1);

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_TOGGLE    = 3'd1,
    KIND_DUTY_UP   = 3'd2,
    KIND_DUTY_DOWN = 3'd3,
    KIND_TIMER_UP  = 3'd4,
    KIND_TIMER_DN  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    BEEP_NONE  = 2'd0,
    BEEP_LIMIT = 2'd1,
    BEEP_GOOD  = 2'd2,
    BEEP_BAD   = 2'd3
  } beep_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTO_MODE = 3'd0,
    REG_SET_TEMP  = 3'd1,
    REG_TIME_0    = 3'd2,
    REG_TIME_1    = 3'd3,
    REG_TIME_2    = 3'd4,
    REG_TIME_3    = 3'd5
  } reg_idx_t;

  localparam logic signed [TEMP_W-1:0] SET_TEMP_RESET = TEMP_W'(75);
  localparam logic [TIME_W-1:0] TIME_0_RESET = TIME_W'(0);
  localparam logic [TIME_W-1:0] TIME_1_RESET = TIME_W'(60);
  localparam logic [TIME_W-1:0] TIME_2_RESET = TIME_W'(120);
  localparam logic [TIME_W-1:0] TIME_3_RESET = TIME_W'(180);

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [TEMP_W-1:0] temperature;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              fan_on;
    logic [MODE_W-1:0] timer_mode_now;
    logic [TIME_W-1:0] timer_left;
    beep_t             beep;
  } out_t;

  typedef struct packed {
    logic                                 auto_mode;
    logic signed [TEMP_W-1:0]             set_temperature;
    logic [TIMER_SLOTS-1:0][TIME_W-1:0]   timer_time;
  } cfg_t;

endpackage

### hdl/fdt_cfg.sv
// ----------------------------------------------------------------------------
// fdt_cfg: configuration register file
// Decodes write beats by index and holds mode, set point and timer table.
// ----------------------------------------------------------------------------
module fdt_cfg
  import fdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_mode       <= 1'b0;
      cfg.set_temperature <= SET_TEMP_RESET;
      cfg.timer_time[0]   <= TIME_0_RESET;
      cfg.timer_time[1]   <= TIME_1_RESET;
      cfg.timer_time[2]   <= TIME_2_RESET;
      cfg.timer_time[3]   <= TIME_3_RESET;
    end else if (wr) begin
      case (cfg_index)
        REG_AUTO_MODE: cfg.auto_mode       <= cfg_data[0];
        REG_SET_TEMP:  cfg.set_temperature <= cfg_data;
        REG_TIME_0:    cfg.timer_time[0]   <= cfg_data;
        REG_TIME_1:    cfg.timer_time[1]   <= cfg_data;
        REG_TIME_2:    cfg.timer_time[2]   <= cfg_data;
        REG_TIME_3:    cfg.timer_time[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/fan_duty_and_timer_controller_top.sv
// ----------------------------------------------------------------------------
// fan_duty_and_timer_controller_top: fan duty and shutoff timer controller
// Datapath: each event beat passes the input register, then the result register.
// Throughput: one event per cycle while out_stall is low; each event updates the fan state once.
// Reset (synchronous rst): fan off, duty 0, timer mode 0, countdown 0,
// registers back to their defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
module fan_duty_and_timer_controller_top
  import fdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  logic              s1_valid;
  in_t               s1_data;
  logic              out_free;
  logic              advance;

  logic              fan_running, fan_running_next;
  logic [DUTY_W-1:0] duty_level, duty_level_next;
  logic [MODE_W-1:0] timer_mode, timer_mode_next;
  logic [TIME_W-1:0] countdown, countdown_next;
  beep_t             beep_next;

  logic signed [TEMP_W:0] diff;
  logic [DUTY_W-1:0]      auto_duty;
  logic [DUTY_W:0]        diff_x3;
  logic [DUTY_W:0]        duty_up;
  logic [TIME_W-1:0]      count_dec;
  logic [MODE_W-1:0]      mode_up, mode_dn;

  fdt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_comb begin
    diff      = (TEMP_W+1)'(s1_data.temperature) - (TEMP_W+1)'(cfg.set_temperature);
    diff_x3   = {diff[DUTY_W-1:0], 1'b0} + (DUTY_W+1)'(diff[DUTY_W-1:0]);
    if (diff <= 0) begin
      auto_duty = '0;
    end else if (diff > (TEMP_W+1)'(AUTO_DIFF_MAX)) begin
      auto_duty = DUTY_MAX;
    end else begin
      auto_duty = diff_x3[DUTY_W-1:0];
    end
    duty_up   = (DUTY_W+1)'(duty_level) + (DUTY_W+1)'(DUTY_STEP);
    count_dec = countdown - TIME_W'(1);
    mode_up   = timer_mode + MODE_W'(1);
    mode_dn   = timer_mode - MODE_W'(1);
  end

  // next state
  always_comb begin
    fan_running_next = fan_running;
    duty_level_next  = duty_level;
    timer_mode_next  = timer_mode;
    countdown_next   = countdown;
    beep_next        = BEEP_NONE;
    case (s1_data.kind)
      KIND_TICK: begin
        if (cfg.auto_mode) duty_level_next = auto_duty;
        if (timer_mode != '0 && countdown != '0 && fan_running) begin
          countdown_next = count_dec;
          if (count_dec == '0) begin
            timer_mode_next  = '0;
            fan_running_next = 1'b0;
          end
        end
      end
      KIND_TOGGLE: fan_running_next = !fan_running;
      KIND_DUTY_UP: begin
        if (!cfg.auto_mode) begin
          if (duty_level >= DUTY_MAX) begin
            duty_level_next = DUTY_MAX;
            beep_next       = BEEP_LIMIT;
          end else if (duty_up > (DUTY_W+1)'(DUTY_MAX)) begin
            duty_level_next = DUTY_MAX;
          end else begin
            duty_level_next = duty_up[DUTY_W-1:0];
          end
        end
      end
      KIND_DUTY_DOWN: begin
        if (duty_level == '0) begin
          beep_next = BEEP_LIMIT;
        end else if (duty_level < DUTY_STEP) begin
          duty_level_next = '0;
        end else begin
          duty_level_next = duty_level - DUTY_STEP;
        end
      end
      KIND_TIMER_UP: begin
        if (timer_mode < MODE_TOP) begin
          timer_mode_next = mode_up;
          countdown_next  = cfg.timer_time[mode_up];
          beep_next       = BEEP_GOOD;
        end else begin
          beep_next = BEEP_BAD;
        end
      end
      KIND_TIMER_DN: begin
        if (timer_mode == '0) begin
          beep_next = BEEP_BAD;
        end else begin
          timer_mode_next = mode_dn;
          countdown_next  = cfg.timer_time[mode_dn];
          beep_next       = BEEP_GOOD;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_running <= 1'b0;
      duty_level  <= '0;
      timer_mode  <= '0;
      countdown   <= '0;
    end else if (advance) begin
      fan_running <= fan_running_next;
      duty_level  <= duty_level_next;
      timer_mode  <= timer_mode_next;
      countdown   <= countdown_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.duty           <= duty_level_next;
      out_data.fan_on         <= fan_running_next;
      out_data.timer_mode_now <= timer_mode_next;
      out_data.timer_left     <= countdown_next;
      out_data.beep           <= beep_next;
    end
  end

`ifndef ASSERT_OFF
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.duty <= DUTY_MAX)
    else $error("duty above limit");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    timer_mode <= MODE_TOP)
    else $error("timer mode beyond top mode");

  a_countdown_step: assert property (@(posedge clk) disable iff (rst)
    advance && s1_data.kind == KIND_TICK && fan_running && timer_mode != '0
      && countdown != '0 |=> countdown == $past(countdown) - TIME_W'(1))
    else $error("countdown did not step on tick");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(duty_level) && $stable(countdown) && $stable(timer_mode))
    else $error("state changed without an event");
`endif

endmodule
